>>> src/rkc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB kernel convolution package
// Shared widths, register codes, reset values and lane control for the
// normalized 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned KERNEL_SIZE   = 3;
  localparam int unsigned COEF_BITS     = 16;
  localparam int unsigned COEF_FRAC     = 8;
  localparam int unsigned HEIGHT_LIMIT  = 4096;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned PIX_W      = CH_W * CHANNELS;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned KROW_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam int unsigned WGT_W  = COEF_BITS + 4;
  localparam int unsigned PROD_W = CH_W + 1 + COEF_BITS;
  localparam int unsigned ACC_W  = PROD_W + 4;
  localparam int unsigned QUO_W  = CH_W + 1;
  localparam int unsigned BIT_W  = $clog2(QUO_W);

  localparam logic [WIDTH_W-1:0]  WIDTH_RST    = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = HEIGHT_W'(480);
  localparam logic [KROW_W-1:0]   KROW_TOP_RST = '0;
  localparam logic [KROW_W-1:0]   KROW_MID_RST = KROW_W'(16777216);
  localparam logic [KROW_W-1:0]   KROW_BOT_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 0,
    REG_IMAGE_HEIGHT = 1,
    REG_KROW_TOP     = 2,
    REG_KROW_MIDDLE  = 3,
    REG_KROW_BOTTOM  = 4
  } reg_idx_e;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic             mac_en;
    logic             mac_first;
    logic             div_init;
    logic             div_en;
    logic [BIT_W-1:0] div_bit;
  } lane_ctrl_t;

  function automatic logic signed [COEF_BITS-1:0] coef_of(input logic [KROW_W-1:0] row,
                                                         input logic [1:0] col);
    logic signed [COEF_BITS-1:0] c;
    case (col)
      2'd0: c = row[COEF_BITS-1:0];
      2'd1: c = row[2*COEF_BITS-1:COEF_BITS];
      default: c = row[3*COEF_BITS-1:2*COEF_BITS];
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/rkc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying one push or flush request with its pixel.
// ----------------------------------------------------------------------------
interface rkc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output operation, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input operation, input red, input green, input blue,
                output ready);
endinterface
`default_nettype wire

>>> src/rkc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying one filtered pixel and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface rkc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input frame_end, output ready);
endinterface
`default_nettype wire

>>> src/rkc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface rkc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/rkc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; a read returns the old data.
// ----------------------------------------------------------------------------
module rkc_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> src/rkc_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Channel lane
// Multiply-accumulates one color channel over the window, then divides the
// sum by the kernel weight one quotient bit per cycle and clamps to 0..255.
// ----------------------------------------------------------------------------
module rkc_lane (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  rkc_pkg::lane_ctrl_t                        ctrl_i,
  input  logic [rkc_pkg::CH_W-1:0]                   chan_i,
  input  logic signed [rkc_pkg::COEF_BITS-1:0]       coef_i,
  input  logic signed [rkc_pkg::WGT_W-1:0]           weight_i,
  output logic [rkc_pkg::CH_W-1:0]                   res_o
);

  localparam int unsigned ACC_W  = rkc_pkg::ACC_W;
  localparam int unsigned PROD_W = rkc_pkg::PROD_W;
  localparam int unsigned WGT_W  = rkc_pkg::WGT_W;
  localparam int unsigned QUO_W  = rkc_pkg::QUO_W;
  localparam int unsigned CH_W   = rkc_pkg::CH_W;

  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]         rem_q;
  logic [ACC_W-1:0]         dvs_q;
  logic [QUO_W-1:0]         quo_q;
  logic                     zero_q;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_base;
  logic [ACC_W-1:0]         acc_abs;
  logic [WGT_W-1:0]         wgt_abs;
  logic [ACC_W-1:0]         dvs_shift;

  assign prod      = PROD_W'($signed({1'b0, chan_i})) * PROD_W'(coef_i);
  assign acc_base  = ctrl_i.mac_first ? '0 : acc_q;
  assign acc_abs   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign wgt_abs   = weight_i[WGT_W-1] ? WGT_W'(-weight_i) : WGT_W'(weight_i);
  assign dvs_shift = dvs_q << ctrl_i.div_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      zero_q <= 1'b1;
    end else begin
      if (ctrl_i.mac_en) begin
        acc_q <= acc_base + ACC_W'(prod);
      end
      if (ctrl_i.div_init) begin
        // A negative quotient clamps to zero, as does a zero sum.
        zero_q <= (acc_q == '0) || (acc_q[ACC_W-1] != weight_i[WGT_W-1]);
        rem_q  <= acc_abs;
        dvs_q  <= ACC_W'(wgt_abs);
        quo_q  <= '0;
      end
      if (ctrl_i.div_en && (rem_q >= dvs_shift)) begin
        rem_q                 <= rem_q - dvs_shift;
        quo_q[ctrl_i.div_bit] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (zero_q) begin
      res_o = '0;
    end else if (quo_q[QUO_W-1]) begin
      res_o = {CH_W{1'b1}};
    end else begin
      res_o = quo_q[CH_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> src/rkc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Output merge stage
// Gathers the three lane results and the end-of-frame flag into the output
// register, which holds the pixel until the consumer takes it.
// ----------------------------------------------------------------------------
module rkc_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic [rkc_pkg::CH_W-1:0] red_i,
  input  logic [rkc_pkg::CH_W-1:0] green_i,
  input  logic [rkc_pkg::CH_W-1:0] blue_i,
  input  logic                     frame_end_i,
  output logic                     free_o,
  rkc_out_if.source                out_o
);

  logic                     valid_q;
  logic [rkc_pkg::CH_W-1:0] red_q;
  logic [rkc_pkg::CH_W-1:0] green_q;
  logic [rkc_pkg::CH_W-1:0] blue_q;
  logic                     fend_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      fend_q  <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      fend_q  <= frame_end_i;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_red   = red_q;
  assign out_o.out_green = green_q;
  assign out_o.out_blue  = blue_q;
  assign out_o.frame_end = fend_q;

endmodule
`default_nettype wire

>>> src/rgb_kernel_convolution.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB kernel convolution
// Streams raster-order RGB pixels through a two-row line store and a 3x3
// window, convolves each channel in its own lane and normalizes by the
// kernel weight with edge pixels repeated at the frame border.
// ----------------------------------------------------------------------------
// A push that completes an output runs the push, multiply-accumulate, divider
// init, divide and emit states; a push without output ends after the push state
// and a flush in the last row first loads the window. One request is in work at
// a time: each lane runs a nine-step multiply-accumulate and a nine-step divider.
// Reset clears counters, window and registers to their defaults; the line
// store is not cleared, and entries are read only after this frame wrote them.
module rgb_kernel_convolution #(
  parameter int unsigned MAX_WIDTH = rkc_pkg::MAX_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rkc_in_if.sink    pix_in_i,
  rkc_out_if.source pix_out_o,
  rkc_cfg_if.sink   cfg_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = rkc_pkg::HEIGHT_W;
  localparam int unsigned CH_W  = rkc_pkg::CH_W;
  localparam int unsigned WGT_W = rkc_pkg::WGT_W;
  localparam int unsigned BIT_W = rkc_pkg::BIT_W;
  localparam int unsigned KS    = rkc_pkg::KERNEL_SIZE;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_LOAD,
    ST_MAC,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                          state_q;
  logic [rkc_pkg::WIDTH_W-1:0]     img_w_q;
  logic [HW-1:0]                   img_h_q;
  logic [rkc_pkg::KROW_W-1:0]      ktop_q;
  logic [rkc_pkg::KROW_W-1:0]      kmid_q;
  logic [rkc_pkg::KROW_W-1:0]      kbot_q;
  logic [CW-1:0]                   in_col_q;
  logic [HW-1:0]                   in_row_q;
  logic [CW-1:0]                   out_col_q;
  logic [HW-1:0]                   out_row_q;
  rkc_pkg::pix_t                   taps_q [KS][KS];
  rkc_pkg::pix_t                   pix_q;
  logic                            par_q;
  logic                            ge1_q;
  logic                            ge2_q;
  logic                            rdy_q;
  logic                            top_q;
  logic                            bot_q;
  logic                            left_q;
  logic                            right_q;
  logic                            fend_q;
  logic [1:0]                      i_q;
  logic [1:0]                      j_q;
  logic [BIT_W-1:0]                cnt_q;
  logic signed [WGT_W-1:0]         weight_q;

  logic [31:0]                     w32;
  logic [31:0]                     h32;
  logic [WW-1:0]                   eff_w;
  logic [HW-1:0]                   eff_h;
  logic                            in_acc;
  logic                            cfg_acc;
  logic                            is_flush;
  logic                            frame_done;
  logic [HW-1:0]                   ir_eff;
  logic [CW-1:0]                   ic_eff;
  logic                            col_wrap;
  logic                            fl_ok;
  logic                            fl_last;
  logic                            out_right;
  logic                            out_bot;
  logic                            begin_emit;
  rkc_pkg::pix_t                   pix_in;
  rkc_pkg::pix_t                   rd_even;
  rkc_pkg::pix_t                   rd_odd;
  rkc_pkg::pix_t                   rd_same;
  rkc_pkg::pix_t                   rd_other;
  rkc_pkg::pix_t                   row_cur;
  rkc_pkg::pix_t                   row_prev;
  rkc_pkg::pix_t                   mid_val;
  rkc_pkg::pix_t                   top_val;
  rkc_pkg::pix_t                   tap_sel;
  logic [CW-1:0]                   ld_col;
  logic [CW-1:0]                   raddr;
  logic                            we;
  logic [1:0]                      sr;
  logic [1:0]                      sc;
  logic [1:0]                      cap_col;
  logic [rkc_pkg::KROW_W-1:0]      krow_sel;
  logic signed [rkc_pkg::COEF_BITS-1:0] coef_sel;
  logic signed [WGT_W-1:0]         weight_eff;
  logic                            mac_first;
  logic                            merge_free;
  logic                            merge_load;
  rkc_pkg::lane_ctrl_t             lane_ctrl;
  logic [CH_W-1:0]                 lane_res [rkc_pkg::CHANNELS];

  always_comb begin
    if (img_w_q == '0) begin
      w32 = 32'd1;
    end else if (32'(img_w_q) > MAX_WIDTH) begin
      w32 = MAX_WIDTH;
    end else begin
      w32 = 32'(img_w_q);
    end
    if (img_h_q == '0) begin
      h32 = 32'd1;
    end else if (32'(img_h_q) > rkc_pkg::HEIGHT_LIMIT) begin
      h32 = rkc_pkg::HEIGHT_LIMIT;
    end else begin
      h32 = 32'(img_h_q);
    end
  end

  assign eff_w = w32[WW-1:0];
  assign eff_h = h32[HW-1:0];

  assign in_acc   = pix_in_i.valid && pix_in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign is_flush = rkc_pkg::op_e'(pix_in_i.operation) == rkc_pkg::OP_FLUSH;
  assign pix_in   = {pix_in_i.blue, pix_in_i.green, pix_in_i.red};

  assign frame_done = in_row_q >= eff_h;
  assign ir_eff     = frame_done ? '0 : in_row_q;
  assign ic_eff     = frame_done ? '0 : in_col_q;
  assign col_wrap   = (WW'(ic_eff) + WW'(1)) >= eff_w;
  assign fl_ok      = frame_done && (out_row_q < eff_h);
  assign fl_last    = (out_row_q + HW'(1)) >= eff_h;
  assign out_right  = (WW'(out_col_q) + WW'(1)) >= eff_w;
  assign out_bot    = (out_row_q + HW'(1)) >= eff_h;

  assign begin_emit = ((state_q == ST_IDLE) && in_acc && is_flush && fl_ok && !fl_last)
                   || ((state_q == ST_PUSH) && rdy_q)
                   || ((state_q == ST_LOAD) && (cnt_q == BIT_W'(3)));

  // Line store: even rows in one RAM, odd rows in the other.
  always_comb begin
    case (cnt_q[1:0])
      2'd0: ld_col = (out_col_q == '0) ? out_col_q : out_col_q - CW'(1);
      2'd1: ld_col = out_col_q;
      default: ld_col = out_right ? out_col_q : out_col_q + CW'(1);
    endcase
  end

  assign raddr = (state_q == ST_LOAD) ? ld_col : ic_eff;
  assign we    = (state_q == ST_IDLE) && in_acc && !is_flush;

  rkc_ram #(
    .WIDTH  (rkc_pkg::PIX_W),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW)
  ) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (we && !ir_eff[0]),
    .waddr_i (ic_eff),
    .wdata_i (pix_in),
    .raddr_i (raddr),
    .rdata_o (rd_even)
  );

  rkc_ram #(
    .WIDTH  (rkc_pkg::PIX_W),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW)
  ) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (we && ir_eff[0]),
    .waddr_i (ic_eff),
    .wdata_i (pix_in),
    .raddr_i (raddr),
    .rdata_o (rd_odd)
  );

  assign rd_same  = par_q ? rd_odd : rd_even;
  assign rd_other = par_q ? rd_even : rd_odd;
  assign mid_val  = ge1_q ? rd_other : pix_q;
  assign top_val  = ge2_q ? rd_same : mid_val;

  assign row_cur  = out_row_q[0] ? rd_odd : rd_even;
  assign row_prev = out_row_q[0] ? rd_even : rd_odd;
  assign cap_col  = cnt_q[1:0] - 2'd1;

  // Window tap and coefficient for the current step, edges repeated.
  always_comb begin
    case (i_q)
      2'd0: sr = top_q ? 2'd1 : 2'd0;
      2'd1: sr = 2'd1;
      default: sr = bot_q ? 2'd1 : 2'd2;
    endcase
    case (j_q)
      2'd0: sc = left_q ? 2'd1 : 2'd0;
      2'd1: sc = 2'd1;
      default: sc = right_q ? 2'd1 : 2'd2;
    endcase
    case (i_q)
      2'd0: krow_sel = kbot_q;
      2'd1: krow_sel = kmid_q;
      default: krow_sel = ktop_q;
    endcase
  end

  assign tap_sel    = taps_q[sr][sc];
  assign coef_sel   = rkc_pkg::coef_of(krow_sel, 2'd2 - j_q);
  assign mac_first  = (i_q == 2'd0) && (j_q == 2'd0);
  assign weight_eff = (weight_q == '0) ? WGT_W'(1 << rkc_pkg::COEF_FRAC) : weight_q;

  assign lane_ctrl.mac_en    = state_q == ST_MAC;
  assign lane_ctrl.mac_first = mac_first;
  assign lane_ctrl.div_init  = state_q == ST_DINIT;
  assign lane_ctrl.div_en    = state_q == ST_DIV;
  assign lane_ctrl.div_bit   = cnt_q;

  for (genvar g = 0; g < rkc_pkg::CHANNELS; g++) begin : g_lane
    rkc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .chan_i   (tap_sel[g*CH_W +: CH_W]),
      .coef_i   (coef_sel),
      .weight_i (weight_eff),
      .res_o    (lane_res[g])
    );
  end

  assign merge_load = (state_q == ST_EMIT) && merge_free;

  rkc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (merge_load),
    .red_i       (lane_res[0]),
    .green_i     (lane_res[1]),
    .blue_i      (lane_res[2]),
    .frame_end_i (fend_q),
    .free_o      (merge_free),
    .out_o       (pix_out_o)
  );

  assign pix_in_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_i.ready    = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      img_w_q   <= rkc_pkg::WIDTH_RST;
      img_h_q   <= rkc_pkg::HEIGHT_RST;
      ktop_q    <= rkc_pkg::KROW_TOP_RST;
      kmid_q    <= rkc_pkg::KROW_MID_RST;
      kbot_q    <= rkc_pkg::KROW_BOT_RST;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      taps_q    <= '{default: '0};
      pix_q     <= '0;
      par_q     <= 1'b0;
      ge1_q     <= 1'b0;
      ge2_q     <= 1'b0;
      rdy_q     <= 1'b0;
      top_q     <= 1'b0;
      bot_q     <= 1'b0;
      left_q    <= 1'b0;
      right_q   <= 1'b0;
      fend_q    <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      cnt_q     <= '0;
      weight_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_flush) begin
              if (fl_ok && fl_last) begin
                cnt_q   <= '0;
                state_q <= ST_LOAD;
              end else if (fl_ok) begin
                for (int r = 0; r < KS; r++) begin
                  taps_q[r][0] <= taps_q[r][1];
                  taps_q[r][1] <= taps_q[r][2];
                end
                state_q <= ST_MAC;
              end
            end else begin
              pix_q    <= pix_in;
              par_q    <= ir_eff[0];
              ge1_q    <= ir_eff != '0;
              ge2_q    <= ir_eff >= HW'(2);
              rdy_q    <= (ir_eff >= HW'(2)) || ((ir_eff == HW'(1)) && (ic_eff != '0));
              in_col_q <= col_wrap ? '0 : ic_eff + CW'(1);
              in_row_q <= col_wrap ? ir_eff + HW'(1) : ir_eff;
              if (frame_done) begin
                out_col_q <= '0;
                out_row_q <= '0;
              end
              state_q <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          for (int r = 0; r < KS; r++) begin
            taps_q[r][0] <= taps_q[r][1];
            taps_q[r][1] <= taps_q[r][2];
          end
          taps_q[0][2] <= top_val;
          taps_q[1][2] <= mid_val;
          taps_q[2][2] <= pix_q;
          state_q      <= rdy_q ? ST_MAC : ST_IDLE;
        end
        ST_LOAD: begin
          if (cnt_q != '0) begin
            taps_q[0][cap_col] <= (out_row_q != '0) ? row_prev : row_cur;
            taps_q[1][cap_col] <= row_cur;
            taps_q[2][cap_col] <= row_cur;
          end
          cnt_q <= cnt_q + BIT_W'(1);
          if (cnt_q == BIT_W'(3)) begin
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          weight_q <= (mac_first ? '0 : weight_q) + WGT_W'(coef_sel);
          if (j_q == 2'd2) begin
            j_q <= 2'd0;
            i_q <= i_q + 2'd1;
            if (i_q == 2'd2) begin
              state_q <= ST_DINIT;
            end
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
        ST_DINIT: begin
          cnt_q   <= BIT_W'(rkc_pkg::QUO_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - BIT_W'(1);
          end
        end
        ST_EMIT: begin
          if (merge_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (begin_emit) begin
        top_q   <= out_row_q == '0;
        bot_q   <= out_bot;
        left_q  <= out_col_q == '0;
        right_q <= out_right;
        fend_q  <= out_bot && out_right;
        i_q     <= '0;
        j_q     <= '0;
        if (out_right) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + HW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end

      if (cfg_acc) begin
        case (rkc_pkg::reg_idx_e'(cfg_i.index))
          rkc_pkg::REG_IMAGE_WIDTH: begin
            img_w_q   <= cfg_i.data[rkc_pkg::WIDTH_W-1:0];
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end
          rkc_pkg::REG_IMAGE_HEIGHT: begin
            img_h_q   <= cfg_i.data[HW-1:0];
            in_col_q  <= '0;
            in_row_q  <= '0;
            out_col_q <= '0;
            out_row_q <= '0;
          end
          rkc_pkg::REG_KROW_TOP:    ktop_q <= cfg_i.data;
          rkc_pkg::REG_KROW_MIDDLE: kmid_q <= cfg_i.data;
          rkc_pkg::REG_KROW_BOTTOM: kbot_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire
